### hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the sparse polynomial multiplier
// Beat layouts, action codes, term store entry and the control group that
// the sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int COEF_W = 16;
  localparam int EXP_W  = 5;
  localparam int SUM_W  = 40;
  localparam int SEXP_W = 6;
  localparam int PROD_W = 2 * COEF_W;

  // saturation limits of the 40-bit accumulators
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_LOAD_A = 2'd0,
    ACT_LOAD_B = 2'd1,
    ACT_MULT   = 2'd2,
    ACT_CLEAR  = 2'd3
  } spm_action_t;

  typedef struct packed {
    spm_action_t              action;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exponent;
  } spm_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum_coef;
    logic [SEXP_W-1:0]       sum_exponent;
    logic                    last;
    logic                    empty_res;
    logic                    dropped;
  } spm_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exponent;
  } spm_term_t;

  typedef struct packed {
    logic              mul_en;
    logic              acc_en;
    logic              clr_pres;
    logic [SEXP_W-1:0] scan_addr;
  } spm_mac_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/spm_term_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_term_ram: term store of one polynomial
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spm_term_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  spm_pkg::spm_term_t  wr_data,
  input  logic [AW-1:0]       rd_addr,
  output spm_pkg::spm_term_t  rd_data
);
  import spm_pkg::*;

  spm_term_t mem [DEPTH];
  spm_term_t rd_data_r;

  // write the loaded term, register the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### hw/rtl/spm_mac_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spm_mac_unit: shared multiply-accumulate unit
// Multiplies one term pair, read-modify-writes the sum memory at the
// product exponent with saturation, and keeps presence bits and the
// highest exponent hit. The same read port serves the emit scan.
// ----------------------------------------------------------------------------
module spm_mac_unit #(
  parameter int SLOTS = 63,
  parameter int SW    = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spm_pkg::spm_mac_ctl_t               ctl,
  input  spm_pkg::spm_term_t                  term_a,
  input  spm_pkg::spm_term_t                  term_b,
  output logic signed [spm_pkg::SUM_W-1:0]    rd_sum,
  output logic                                rd_pres,
  output logic [SW-1:0]                       max_exp
);
  import spm_pkg::*;

  logic [SUM_W-1:0]  sum_mem [SLOTS];
  logic [SUM_W-1:0]  rd_sum_r;
  logic              rd_pres_r;
  logic [PROD_W-1:0] prod_r;
  logic [SW-1:0]     pe_r;
  logic [SLOTS-1:0]  pres_r;
  logic [SW-1:0]     max_r;

  logic [SEXP_W-1:0] pe_full;
  logic [SW-1:0]     pe_c;
  logic [SW-1:0]     rd_addr;
  logic [SUM_W-1:0]  acc_base;
  logic [SUM_W:0]    acc_wide;
  logic [SUM_W-1:0]  acc_sat;

  // product exponent of the pair on the term ports
  assign pe_full = SEXP_W'(term_a.exponent) + SEXP_W'(term_b.exponent);
  assign pe_c    = pe_full[SW-1:0];
  assign rd_addr = ctl.mul_en ? pe_c : ctl.scan_addr[SW-1:0];

  // add the product to the old sum, clamp at the 40-bit limits
  always_comb begin
    acc_base = rd_pres_r ? rd_sum_r : '0;
    acc_wide = {acc_base[SUM_W-1], acc_base}
             + {{(SUM_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    if (acc_wide[SUM_W] != acc_wide[SUM_W-1]) begin
      acc_sat = acc_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sat = acc_wide[SUM_W-1:0];
    end
  end

  // sum memory, multiplier and read registers
  always_ff @(posedge clk) begin
    rd_sum_r  <= sum_mem[rd_addr];
    rd_pres_r <= pres_r[rd_addr];
    if (ctl.mul_en) begin
      prod_r <= $signed(term_a.coef) * $signed(term_b.coef);
      pe_r   <= pe_c;
    end
    if (ctl.acc_en) begin
      sum_mem[pe_r] <= acc_sat;
    end
  end

  // presence bits and highest exponent hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= '0;
      max_r  <= '0;
    end else if (ctl.clr_pres) begin
      pres_r <= '0;
      max_r  <= '0;
    end else if (ctl.acc_en) begin
      pres_r[pe_r] <= 1'b1;
      if (pe_r > max_r) begin
        max_r <= pe_r;
      end
    end
  end

  assign rd_sum  = rd_sum_r;
  assign rd_pres = rd_pres_r;
  assign max_exp = max_r;

endmodule
`default_nettype wire

### hw/rtl/sparse_polynomial_multiply_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_multiply_top: sparse polynomial multiplier
// Loads two term lists, multiplies them pair by pair through one shared
// multiply-accumulate unit and emits the product terms in ascending order.
//
//   channel  ports                       handshake
//   input    start, busy, in_data        beat taken when start && !busy
//   result   out_valid, out_data         one-cycle strobe, no back-pressure
//
// Load and clear beats leave busy low. A multiply with an empty polynomial
// also leaves busy low; its result follows in the next cycle. Otherwise
// busy holds while each term pair passes term read, multiply and sum
// read-modify-write, then while the scan visits each exponent up to the
// highest product exponent E, and through the drain state.
// Reset is synchronous; presence bits clear at once, so no clearing pass.
// ----------------------------------------------------------------------------
module sparse_polynomial_multiply_top #(
  parameter int MAX_TERMS = 16,
  parameter int MAX_EXP   = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  spm_pkg::spm_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output spm_pkg::spm_out_t out_data
);
  import spm_pkg::*;

  localparam int IW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int SLOTS = 2 * MAX_EXP + 1;
  localparam int SW    = $clog2(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_SCAN,
    S_DRAIN
  } state_t;

  state_t        state_r;
  logic [CW-1:0] f_cnt_r;
  logic [CW-1:0] s_cnt_r;
  logic          ovf_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic [SW-1:0] k_r;
  logic          pend_r;
  logic [SW-1:0] kd_r;
  logic          lastd_r;
  logic          out_valid_r;
  spm_out_t      out_data_r;

  logic          accept;
  logic          exp_bad;
  logic          f_full;
  logic          s_full;
  logic          f_wr;
  logic          s_wr;
  logic          mult_empty;
  logic          i_last;
  logic          j_last;
  logic          k_last;
  spm_term_t     new_term;
  spm_term_t     f_rd;
  spm_term_t     s_rd;
  spm_mac_ctl_t  mac_ctl;
  logic [SUM_W-1:0] mac_rd_sum;
  logic          mac_rd_pres;
  logic [SW-1:0] mac_max;

  // decode the input beat
  assign accept     = start && !busy;
  assign exp_bad    = in_data.exponent > EXP_W'(MAX_EXP);
  assign f_full     = f_cnt_r >= CW'(MAX_TERMS);
  assign s_full     = s_cnt_r >= CW'(MAX_TERMS);
  assign f_wr       = accept && (in_data.action == ACT_LOAD_A) && !f_full && !exp_bad;
  assign s_wr       = accept && (in_data.action == ACT_LOAD_B) && !s_full && !exp_bad;
  assign mult_empty = (f_cnt_r == '0) || (s_cnt_r == '0);
  assign new_term   = '{coef: in_data.coef, exponent: in_data.exponent};

  // loop bounds
  assign i_last = (CW'(i_r) + CW'(1)) == f_cnt_r;
  assign j_last = (CW'(j_r) + CW'(1)) == s_cnt_r;
  assign k_last = k_r == mac_max;

  // control group for the shared unit
  always_comb begin
    mac_ctl.mul_en    = state_r == S_MUL;
    mac_ctl.acc_en    = state_r == S_ACC;
    mac_ctl.clr_pres  = (state_r == S_DRAIN)
                     || (accept && (in_data.action == ACT_CLEAR));
    mac_ctl.scan_addr = SEXP_W'(k_r);
  end

  spm_term_ram #(
    .DEPTH (MAX_TERMS),
    .AW    (IW)
  ) u_first (
    .clk     (clk),
    .wr_en   (f_wr),
    .wr_addr (f_cnt_r[IW-1:0]),
    .wr_data (new_term),
    .rd_addr (i_r),
    .rd_data (f_rd)
  );

  spm_term_ram #(
    .DEPTH (MAX_TERMS),
    .AW    (IW)
  ) u_second (
    .clk     (clk),
    .wr_en   (s_wr),
    .wr_addr (s_cnt_r[IW-1:0]),
    .wr_data (new_term),
    .rd_addr (j_r),
    .rd_data (s_rd)
  );

  spm_mac_unit #(
    .SLOTS (SLOTS),
    .SW    (SW)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mac_ctl),
    .term_a  (f_rd),
    .term_b  (s_rd),
    .rd_sum  (mac_rd_sum),
    .rd_pres (mac_rd_pres),
    .max_exp (mac_max)
  );

  // sequencer: state, counters and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      f_cnt_r     <= '0;
      s_cnt_r     <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // strobe a present scanned slot, or the flagged beat of an empty multiply
      out_valid_r <= (pend_r && mac_rd_pres)
                  || (accept && (in_data.action == ACT_MULT) && mult_empty);
      pend_r      <= state_r == S_SCAN;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_data.action)
              ACT_LOAD_A: begin
                if (f_full || exp_bad) ovf_r <= 1'b1;
                else f_cnt_r <= f_cnt_r + CW'(1);
              end
              ACT_LOAD_B: begin
                if (s_full || exp_bad) ovf_r <= 1'b1;
                else s_cnt_r <= s_cnt_r + CW'(1);
              end
              ACT_MULT: begin
                if (!mult_empty) begin
                  i_r     <= '0;
                  j_r     <= '0;
                  state_r <= S_RD;
                end
              end
              ACT_CLEAR: begin
                f_cnt_r <= '0;
                s_cnt_r <= '0;
                ovf_r   <= 1'b0;
              end
            endcase
          end
        end
        S_RD:  state_r <= S_MUL;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          // second polynomial outer, first inner
          if (i_last) begin
            i_r <= '0;
            if (j_last) begin
              k_r     <= '0;
              state_r <= S_SCAN;
            end else begin
              j_r     <= j_r + IW'(1);
              state_r <= S_RD;
            end
          end else begin
            i_r     <= i_r + IW'(1);
            state_r <= S_RD;
          end
        end
        S_SCAN: begin
          k_r <= k_r + SW'(1);
          if (k_last) state_r <= S_DRAIN;
        end
        S_DRAIN: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    kd_r    <= k_r;
    lastd_r <= k_last;
    if (pend_r) begin
      out_data_r <= '{sum_coef: mac_rd_sum, sum_exponent: SEXP_W'(kd_r),
                      last: lastd_r, empty_res: 1'b0, dropped: ovf_r};
    end else if (accept && (in_data.action == ACT_MULT) && mult_empty) begin
      out_data_r <= '{sum_coef: '0, sum_exponent: '0,
                      last: 1'b1, empty_res: 1'b1, dropped: ovf_r};
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // term counts never pass the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (f_cnt_r <= CW'(MAX_TERMS)) && (s_cnt_r <= CW'(MAX_TERMS)))
    else $error("term count beyond store depth");

  // an empty multiply answers next cycle with one flagged result
  a_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.action == ACT_MULT) && mult_empty
    |=> out_valid && out_data.empty_res && out_data.last)
    else $error("empty multiply gave no flagged result");

  // the final result of a multiply shows once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("last result while still busy");

  // results before the last only come out during a multiply
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-last result outside a multiply");

endmodule
`default_nettype wire
